[hw/rtl/dd2b_pkg.sv]
`default_nettype none

package dd2b_pkg;

	localparam int DIGIT_W    = 4;
	localparam int WORD_W     = 64;
	localparam int WORD_SH    = 6;

	// largest legal decimal digit, and the carry an odd digit hands to the next
	localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
	localparam logic [DIGIT_W-1:0] HALF_CARRY = 4'd5;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
		logic               bad;
	} dd2b_entry_t;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_CONVERT,
		ST_EMIT
	} dd2b_state_t;

endpackage

`default_nettype wire

[hw/rtl/dd2b_if.sv]
`default_nettype none

// digit word channel
interface dd2b_digit_if;
	logic                        valid;
	logic                        ready;
	logic [dd2b_pkg::DIGIT_W-1:0] digit;
	logic                        last_digit;

	modport source (output valid, output digit, output last_digit, input ready);
	modport sink   (input valid, input digit, input last_digit, output ready);
endinterface

// result word channel
interface dd2b_word_if;
	logic                       valid;
	logic                       ready;
	logic [dd2b_pkg::WORD_W-1:0] binary_word;
	logic                       word_index;
	logic                       too_large;
	logic                       last_word;

	modport source (output valid, output binary_word, output word_index,
		output too_large, output last_word, input ready);
	modport sink   (input valid, input binary_word, input word_index,
		input too_large, input last_word, output ready);
endinterface

`default_nettype wire

[hw/rtl/dd2b_front.sv]
`default_nettype none

module dd2b_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	dd2b_digit_if.sink             digits,
	output dd2b_pkg::dd2b_entry_t  entry,
	output logic                   entry_valid,
	input  wire logic              entry_pop
);

	localparam int DEPTH = 2;

	dd2b_pkg::dd2b_entry_t slot_q [DEPTH];
	dd2b_pkg::dd2b_entry_t classified;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;

	// non-decimal codes go in as zero with the error mark set
	always_comb begin
		classified.bad   = digits.digit > dd2b_pkg::DIGIT_MAX;
		classified.digit = classified.bad ? '0 : digits.digit;
		classified.last  = digits.last_digit;
	end

	assign digits.ready = fill_q != 2'(DEPTH);
	assign push         = digits.valid && digits.ready;
	assign entry_valid  = fill_q != 2'd0;
	assign pop          = entry_pop && entry_valid;
	assign entry        = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/dd2b_back.sv]
`default_nettype none

module dd2b_back #(
	parameter int MAX_DIGITS   = 40,
	parameter int RESULT_WORDS = 2
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dd2b_pkg::dd2b_entry_t  entry,
	input  wire logic                   entry_valid,
	output logic                        entry_pop,
	dd2b_word_if.source                 words
);

	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int RES_W  = dd2b_pkg::WORD_W * RESULT_WORDS;
	localparam int BIT_W  = $clog2(RES_W);
	localparam int WIDX_W = (RESULT_WORDS > 1) ? $clog2(RESULT_WORDS) : 1;
	localparam int DW     = dd2b_pkg::DIGIT_W;

	dd2b_pkg::dd2b_state_t state_q, state_d;

	// cell 0 holds the least significant digit
	logic [DW-1:0]     digit_q  [MAX_DIGITS];
	logic [DW-1:0]     masked   [MAX_DIGITS+1];
	logic [DW-1:0]     halved   [MAX_DIGITS];
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [BIT_W-1:0]  bit_q;
	logic [WIDX_W-1:0] word_q;
	logic [RES_W-1:0]  result_q;
	logic [RES_W-1:0]  result_next;
	logic              too_large_q;
	logic              residue;
	logic              store;
	logic              store_room;
	logic              conv_done;
	logic              word_taken;

	// one halving pass over all cells at once
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			masked[i] = (CNT_W'(i) < count_q) ? digit_q[i] : '0;
		end
		masked[MAX_DIGITS] = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			halved[i] = {1'b0, masked[i][DW-1:1]}
				+ (masked[i+1][0] ? dd2b_pkg::HALF_CARRY : '0);
		end
		residue = 1'b0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			residue = residue | (|halved[i]);
		end
	end

	assign result_next = {masked[0][0], result_q[RES_W-1:1]};
	assign store_room  = count_q < CNT_W'(MAX_DIGITS);
	assign conv_done   = bit_q == BIT_W'(RES_W - 1);
	assign word_taken  = words.valid && words.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dd2b_pkg::ST_COLLECT: begin
				if (entry_valid && entry.last) begin
					state_d = dd2b_pkg::ST_CONVERT;
				end
			end
			dd2b_pkg::ST_CONVERT: begin
				if (conv_done) begin
					state_d = dd2b_pkg::ST_EMIT;
				end
			end
			dd2b_pkg::ST_EMIT: begin
				if (word_taken && word_q == '0) begin
					state_d = dd2b_pkg::ST_COLLECT;
				end
			end
			default: state_d = dd2b_pkg::ST_COLLECT;
		endcase
	end

	// outputs; digits that do not end a number may enter while words drain
	always_comb begin
		entry_pop   = 1'b0;
		words.valid = 1'b0;
		unique case (state_q)
			dd2b_pkg::ST_COLLECT: entry_pop = entry_valid;
			dd2b_pkg::ST_CONVERT: entry_pop = 1'b0;
			dd2b_pkg::ST_EMIT: begin
				entry_pop   = entry_valid && !entry.last;
				words.valid = 1'b1;
			end
			default: entry_pop = 1'b0;
		endcase
	end

	assign store             = entry_pop;
	assign words.binary_word = result_q[{word_q, dd2b_pkg::WORD_SH'(0)} +: dd2b_pkg::WORD_W];
	assign words.word_index  = word_q[0];
	assign words.too_large   = too_large_q;
	assign words.last_word   = word_q == '0;

	always_ff @(posedge clk) begin
		if (store && store_room) begin
			digit_q[0] <= entry.digit;
			for (int i = 1; i < MAX_DIGITS; i++) begin
				digit_q[i] <= digit_q[i-1];
			end
		end else if (state_q == dd2b_pkg::ST_CONVERT) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digit_q[i] <= halved[i];
			end
		end
		if (state_q == dd2b_pkg::ST_CONVERT) begin
			if (conv_done && (ovf_q || residue)) begin
				result_q    <= '0;
				too_large_q <= 1'b1;
			end else begin
				result_q    <= result_next;
				too_large_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dd2b_pkg::ST_COLLECT;
			count_q <= '0;
			ovf_q   <= 1'b0;
			bit_q   <= '0;
			word_q  <= '0;
		end else begin
			state_q <= state_d;
			if (store) begin
				if (store_room) begin
					count_q <= count_q + CNT_W'(1);
				end
				ovf_q <= ovf_q | entry.bad | !store_room;
			end else if (state_q == dd2b_pkg::ST_CONVERT && conv_done) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (state_q == dd2b_pkg::ST_CONVERT) begin
				bit_q <= bit_q + BIT_W'(1);
			end else begin
				bit_q <= '0;
			end
			if (state_q == dd2b_pkg::ST_CONVERT && conv_done) begin
				word_q <= WIDX_W'(RESULT_WORDS - 1);
			end else if (word_taken && word_q != '0) begin
				word_q <= word_q - WIDX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/decimal_digits_to_binary.sv]
// decimal digits to binary converter
//
// digits: one decimal digit per word, most significant first, last_digit set
//   on the final digit of a number; codes above nine count as an error
// words: RESULT_WORDS words of 64 bits per number, most significant first,
//   word_index low bit of the word position, last_word on the final word,
//   too_large set (and every word zero) on overflow, on a code above nine
//   or on more than MAX_DIGITS digits
// a two-word queue sits between the classifying front and the converter, so
//   digits can still be taken while the receiver stalls; while the converter
//   halves, the queue takes digits only until it is full
// digits pass through the queue into the digit store; after the last digit
//   the halving loop makes one pass over every stored digit per cycle, one
//   result bit per pass, then the result words go out one per cycle while
//   the receiver is ready
// a stalled receiver holds the current word; digits that do not end a number
//   are still stored meanwhile, the next last digit waits in the queue
// reset clears the queue, the digit count and the error flag; the digit
//   store itself is not cleared, cells above the count read as zero
`default_nettype none

module decimal_digits_to_binary #(
	parameter int MAX_DIGITS   = 40,
	parameter int RESULT_WORDS = 2
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dd2b_digit_if.sink  digits,
	dd2b_word_if.source words
);

	// classified digit between front and converter
	dd2b_pkg::dd2b_entry_t entry;
	logic                  entry_valid;
	logic                  entry_pop;

	// front: range check and queue
	dd2b_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.digits      (digits),
		.entry       (entry),
		.entry_valid (entry_valid),
		.entry_pop   (entry_pop)
	);

	// back: digit store, halving loop and word output
	dd2b_back #(
		.MAX_DIGITS   (MAX_DIGITS),
		.RESULT_WORDS (RESULT_WORDS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (entry),
		.entry_valid (entry_valid),
		.entry_pop   (entry_pop),
		.words       (words)
	);

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	localparam int MAX_DIGITS   = 40;
	localparam int RESULT_WORDS = 2;
	localparam int RESULT_W     = dd2b_pkg::WORD_W * RESULT_WORDS;
	// four bits per held digit always covers ten to the power of the count
	localparam int HELD_W       = 4 * MAX_DIGITS + 4;
	// longest number the block needs, halving loop plus the word drain
	localparam int SETTLE_CYCLES = MAX_DIGITS + RESULT_W + 40;

	typedef logic [dd2b_pkg::DIGIT_W-1:0] digit_q_t[$];

	typedef struct packed {
		logic [dd2b_pkg::WORD_W-1:0] binary_word;
		logic                        word_index;
		logic                        too_large;
		logic                        last_word;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n;

	dd2b_digit_if digit_ch ();
	dd2b_word_if  word_ch ();

	decimal_digits_to_binary #(
		.MAX_DIGITS  (MAX_DIGITS),
		.RESULT_WORDS(RESULT_WORDS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.digits(digit_ch),
		.words (word_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// per-cycle idle chances in percent, changed between phases
	int sender_idle_pct = 25;
	int receiver_idle_pct = 48;
	int digits_sent = 0;
	int error_count = 0;

	// predicted result words, oldest first
	result_word_t pending_words[$];

	// running value of the number being received, as the block should see it
	logic [HELD_W-1:0] held_value = '0;
	int                held_count = 0;
	bit                number_bad = 1'b0;

	// fold one accepted digit word into the running value; on the final digit
	// queue up the result words, most significant first
	task automatic absorb_digit(input logic [dd2b_pkg::DIGIT_W-1:0] d, input logic fin);
		logic [dd2b_pkg::DIGIT_W-1:0] dv;
		logic [RESULT_W-1:0]          bin;
		bit                           too_big;
		result_word_t                 w;
		dv = d;
		// a code above nine poisons the number and is kept as a zero
		if (d > dd2b_pkg::DIGIT_MAX) begin
			number_bad = 1'b1;
			dv = '0;
		end
		// digits past the store depth are dropped, leading zeros included
		if (held_count < MAX_DIGITS) begin
			held_value = held_value * 10 + HELD_W'(dv);
			held_count++;
		end else begin
			number_bad = 1'b1;
		end
		if (fin) begin
			too_big = number_bad || (held_value[HELD_W-1:RESULT_W] != '0);
			// an oversized or malformed number reads back as all-zero words
			bin = too_big ? '0 : held_value[RESULT_W-1:0];
			for (int k = RESULT_WORDS - 1; k >= 0; k--) begin
				w.binary_word = bin[k*dd2b_pkg::WORD_W +: dd2b_pkg::WORD_W];
				w.word_index  = k[0];
				w.too_large   = too_big;
				w.last_word   = (k == 0);
				pending_words = {pending_words, w};
			end
			held_value = '0;
			held_count = 0;
			number_bad = 1'b0;
		end
	endtask

	// drive one digit word, with random idle cycles ahead of it; valid is left
	// high afterwards so back-to-back words never drop it for a cycle
	task automatic send_digit(input logic [dd2b_pkg::DIGIT_W-1:0] d, input logic fin);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			digit_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
		end
		digit_ch.valid      <= 1'b1;
		digit_ch.digit      <= d;
		digit_ch.last_digit <= fin;
		do @(posedge clk); while (digit_ch.ready !== 1'b1);
		digits_sent++;
		absorb_digit(d, fin);
	endtask

	task automatic send_number(input digit_q_t ds);
		foreach (ds[i])
			send_digit(ds[i], i == ds.size() - 1);
	endtask

	// hold the sender off until every predicted word has come back
	task automatic drain_results();
		digit_ch.valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// decimal digits of a value near the width limit, at or just either side of it
	function automatic digit_q_t near_limit_number();
		logic [HELD_W-1:0] v;
		logic [HELD_W-1:0] offs;
		digit_q_t          q;
		offs = ($urandom_range(0, 1) == 0) ? HELD_W'($urandom_range(0, 2))
			: HELD_W'($urandom);
		v = HELD_W'(1) << RESULT_W;
		v = ($urandom_range(0, 1) == 0) ? v - 1 - offs : v + offs;
		while (v != '0) begin
			q.push_front(dd2b_pkg::DIGIT_W'(v % 10));
			v = v / 10;
		end
		if (q.size() < MAX_DIGITS && $urandom_range(0, 3) == 0)
			q.push_front('0);
		return q;
	endfunction

	// mostly short numbers, some long ones, some at the width limit, some over
	// the digit limit and some with a non-decimal code somewhere inside
	function automatic digit_q_t random_number();
		digit_q_t q;
		int       pick;
		int       len;
		pick = $urandom_range(0, 99);
		if (pick >= 75 && pick < 85)
			return near_limit_number();
		if (pick < 60)
			len = $urandom_range(1, 12);
		else if (pick < 75)
			len = $urandom_range(13, MAX_DIGITS);
		else if (pick < 90)
			len = $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 4);
		else
			len = $urandom_range(1, 15);
		for (int i = 0; i < len; i++)
			q = {q, dd2b_pkg::DIGIT_W'($urandom_range(0, 9))};
		// now and then a number of nothing but zeros
		if (pick < 60 && $urandom_range(0, 19) == 0)
			foreach (q[i]) q[i] = '0;
		if (pick >= 90)
			q[$urandom_range(0, len - 1)] = dd2b_pkg::DIGIT_W'($urandom_range(10, 15));
		return q;
	endfunction

	task automatic test_zero_numbers();
		send_number('{4'd0});
		send_number('{4'd0, 4'd0, 4'd0});
		drain_results();
	endtask

	task automatic test_short_numbers();
		send_number('{4'd9});
		send_number('{4'd8, 4'd6});
		send_number('{4'd0, 4'd0, 4'd7, 4'd1});
		drain_results();
	endtask

	task automatic test_bad_codes();
		// error in the middle, then on the final digit itself
		send_number('{4'd1, 4'd15, 4'd2});
		send_number('{4'd10});
		// the error flag must not leak into the following number
		send_number('{4'd3, 4'd5});
		drain_results();
	endtask

	task automatic test_random_numbers(input int snd_pct, input int rcv_pct,
		input int digit_goal);
		int stop_at;
		sender_idle_pct   = snd_pct;
		receiver_idle_pct = rcv_pct;
		stop_at = digits_sent + digit_goal;
		while (digits_sent < stop_at)
			send_number(random_number());
		drain_results();
	endtask

	// receiver side: random stalls, ready low through reset
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_ch.ready <= 1'b0;
		end else begin
			word_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// compare every accepted result word against the oldest prediction
	always @(posedge clk) begin
		result_word_t got;
		result_word_t exp_w;
		if (arst_n === 1'b1 && word_ch.valid === 1'b1 && word_ch.ready === 1'b1) begin
			got.binary_word = word_ch.binary_word;
			got.word_index  = word_ch.word_index;
			got.too_large   = word_ch.too_large;
			got.last_word   = word_ch.last_word;
			if (pending_words.size() == 0) begin
				error_count++;
				$display("%0t: unexpected word %h index=%0d too_large=%0d last=%0d",
					$time, got.binary_word, got.word_index, got.too_large,
					got.last_word);
			end else begin
				exp_w = pending_words.pop_front();
				if (got.binary_word !== exp_w.binary_word
					|| got.word_index !== exp_w.word_index
					|| got.too_large !== exp_w.too_large
					|| got.last_word !== exp_w.last_word) begin
					error_count++;
					$display("%0t: expected %h index=%0d too_large=%0d last=%0d",
						$time, exp_w.binary_word, exp_w.word_index,
						exp_w.too_large, exp_w.last_word);
					$display("%0t: actual   %h index=%0d too_large=%0d last=%0d",
						$time, got.binary_word, got.word_index, got.too_large,
						got.last_word);
				end
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		digit_ch.valid      = 1'b0;
		digit_ch.digit      = '0;
		digit_ch.last_digit = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_numbers();
		test_short_numbers();
		test_bad_codes();

		// receiver sparse first, then sender sparse, then full rate both ways
		test_random_numbers(25, 48, 480);
		test_random_numbers(48, 25, 480);
		test_random_numbers(0, 0, 480);

		// catch stray words after the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_words.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
